>>> rtl/cubic_hermite_fractional_delay_read_defines.svh
// assertion macros for the cubic hermite fractional delay read block
// used by chfdr_checker; no other dependencies
`ifndef CUBIC_HERMITE_FRACTIONAL_DELAY_READ_DEFINES_SVH
`define CUBIC_HERMITE_FRACTIONAL_DELAY_READ_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CHFDR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CHFDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/chfdr_pkg.sv
// shared types and constants for the cubic hermite fractional delay read block
// no dependencies
package chfdr_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int DELAY_W        = 28;
    localparam int LANE_COUNT     = 8;
    localparam int RING_DEPTH_DEF = 4096;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ADDR_MAX_W     = 16;
    localparam int BANKS          = 4;
    localparam int WORK_W         = 26;
    localparam int PIPE_DEPTH     = 9;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [DELAY_W-1:0]         t_delay;

    // ring write group shared by every lane copy
    typedef struct packed {
        logic                  we;
        logic                  clr;
        logic [ADDR_MAX_W-1:0] addr;
        t_sample               data;
    } t_ring_wr;

endpackage

>>> rtl/chfdr_bank.sv
// one bank of the interleaved sample ring: one write port, one registered read
// depends on chfdr_pkg
module chfdr_bank #(
    parameter int ROWS = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [$clog2(ROWS)-1:0] i_waddr,
    input  chfdr_pkg::t_sample      i_wdata,
    input  logic [$clog2(ROWS)-1:0] i_raddr,
    output chfdr_pkg::t_sample      o_rdata
);
    import chfdr_pkg::*;

    t_sample r_mem [ROWS];
    t_sample r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> rtl/chfdr_lane.sv
// one read lane: four-bank ring copy, address split and horner interpolation
// depends on chfdr_pkg and chfdr_bank
module chfdr_lane #(
    parameter int RING_DEPTH = chfdr_pkg::RING_DEPTH_DEF,
    parameter int FRAC_BITS  = chfdr_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  chfdr_pkg::t_ring_wr           i_wr,
    input  logic [$clog2(RING_DEPTH)-1:0] i_newest,
    input  chfdr_pkg::t_delay             i_delay,
    output chfdr_pkg::t_sample            o_tap
);
    import chfdr_pkg::*;

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int ROWS = RING_DEPTH / BANKS;
    localparam int RW   = AW - 2;
    localparam int TW   = FRAC_BITS + 1;
    localparam int PW   = WORK_W + FRAC_BITS + 2;
    localparam logic signed [PW-1:0]     HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [WORK_W-1:0] SMAX = WORK_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [WORK_W-1:0] SMIN = -SMAX - WORK_W'(1);

    function automatic logic signed [WORK_W-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = (p + HALF) >>> FRAC_BITS;
        return s[WORK_W-1:0];
    endfunction

    // address split
    logic [DELAY_W-1:0]  w_dint;
    logic [FRAC_BITS-1:0] w_frac;
    logic                w_nz;
    logic [AW-1:0]       w_base;
    logic [AW-1:0]       w_idx;
    logic [TW-1:0]       w_t;
    logic [RW-1:0]       w_raddr [BANKS];
    t_sample             w_q     [BANKS];

    assign w_dint = i_delay >> FRAC_BITS;
    assign w_frac = i_delay[FRAC_BITS-1:0];
    assign w_nz   = |w_frac;
    assign w_base = i_newest - w_dint[AW-1:0];
    assign w_idx  = w_base - AW'(w_nz);
    assign w_t    = w_nz ? ((TW'(1) << FRAC_BITS) - {1'b0, w_frac}) : '0;

    always_comb begin
        logic [1:0]    k;
        logic [AW-1:0] j;
        for (int b = 0; b < BANKS; b++) begin
            k          = 2'(b) - w_idx[1:0] + 2'd1;
            j          = w_idx + AW'(k) - AW'(1);
            w_raddr[b] = j[AW-1:2];
        end
    end

    for (genvar gb = 0; gb < BANKS; gb++) begin : g_bank
        chfdr_bank #(.ROWS(ROWS)) u_bank (
            .i_clk   (i_clk),
            .i_we    (i_wr.we && (i_wr.clr || i_wr.addr[1:0] == 2'(gb))),
            .i_waddr (i_wr.addr[AW-1:2]),
            .i_wdata (i_wr.data),
            .i_raddr (w_raddr[gb]),
            .o_rdata (w_q[gb])
        );
    end

    // stage registers; t, y0 and d0 hold for the whole item
    logic [TW-1:0]              r_t;
    logic [1:0]                 r_lo;
    logic signed [WORK_W-1:0]   r_y0, r_d0, r_m0, r_m1, r_a, r_b;
    logic signed [PW-1:0]       r_p1, r_p2, r_p3;
    t_sample                    r_tap;

    logic signed [WORK_W-1:0] w_ym1, w_y0, w_y1, w_y2;
    logic signed [WORK_W-1:0] w_dd, w_d1, w_c, w_o;
    logic signed [TW:0]       w_ts;

    assign w_ym1 = WORK_W'(w_q[r_lo - 2'd1]);
    assign w_y0  = WORK_W'(w_q[r_lo]);
    assign w_y1  = WORK_W'(w_q[r_lo + 2'd1]);
    assign w_y2  = WORK_W'(w_q[r_lo + 2'd2]);
    assign w_dd  = w_y1 - w_y0;
    assign w_d1  = w_y2 - w_y0;
    assign w_ts  = {1'b0, r_t};
    assign w_c   = (r_y0 <<< 1) + rnd(r_p3);
    assign w_o   = (w_c + WORK_W'(1)) >>> 1;

    always_ff @(posedge i_clk) begin
        r_t  <= w_t;
        r_lo <= w_idx[1:0];
        r_y0 <= w_y0;
        r_d0 <= w_y1 - w_ym1;
        r_m0 <= WORK_W'(6) * w_dd - WORK_W'(2) * (w_y1 - w_ym1) - w_d1;
        r_m1 <= (w_y1 - w_ym1) - WORK_W'(4) * w_dd + w_d1;
        r_p1 <= PW'(w_ts * r_m1);
        r_a  <= r_m0 + rnd(r_p1);
        r_p2 <= PW'(w_ts * r_a);
        r_b  <= r_d0 + rnd(r_p2);
        r_p3 <= PW'(w_ts * r_b);
        if (w_o > SMAX) begin
            r_tap <= SMAX[SAMPLE_W-1:0];
        end else if (w_o < SMIN) begin
            r_tap <= SMIN[SAMPLE_W-1:0];
        end else begin
            r_tap <= w_o[SAMPLE_W-1:0];
        end
    end

    assign o_tap = r_tap;

endmodule

>>> rtl/cubic_hermite_fractional_delay_read.sv
// top level: cubic hermite fractional delay line with eight read lanes
// depends on chfdr_pkg and chfdr_lane
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_write_sample, i_sample, i_delay_0..7
//  result   out        o_valid / i_stall   o_tap_0..7
//
// one transaction at a time, computed by the lane pipeline (ring read,
//   coefficients, three multiply/round steps)
// the next input is taken only once the previous result leaves the lane pipeline
// after reset a clearing pass zeroes the ring row by row, o_stall high
// a new input is taken while a finished result still waits in the output register
// a stalled result holds; the lane pipeline waits at its last stage until free
module cubic_hermite_fractional_delay_read #(
    parameter int RING_DEPTH      = chfdr_pkg::RING_DEPTH_DEF,
    parameter int DELAY_FRAC_BITS = chfdr_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_write_sample,
    input  chfdr_pkg::t_sample i_sample,
    input  chfdr_pkg::t_delay  i_delay_0,
    input  chfdr_pkg::t_delay  i_delay_1,
    input  chfdr_pkg::t_delay  i_delay_2,
    input  chfdr_pkg::t_delay  i_delay_3,
    input  chfdr_pkg::t_delay  i_delay_4,
    input  chfdr_pkg::t_delay  i_delay_5,
    input  chfdr_pkg::t_delay  i_delay_6,
    input  chfdr_pkg::t_delay  i_delay_7,
    output logic               o_valid,
    input  logic               i_stall,
    output chfdr_pkg::t_sample o_tap_0,
    output chfdr_pkg::t_sample o_tap_1,
    output chfdr_pkg::t_sample o_tap_2,
    output chfdr_pkg::t_sample o_tap_3,
    output chfdr_pkg::t_sample o_tap_4,
    output chfdr_pkg::t_sample o_tap_5,
    output chfdr_pkg::t_sample o_tap_6,
    output chfdr_pkg::t_sample o_tap_7
);
    import chfdr_pkg::*;

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int ROWS = RING_DEPTH / BANKS;
    localparam int RW   = AW - 2;

    // control state
    logic                  r_clr;
    logic [RW-1:0]         r_row;
    logic [AW-1:0]         r_newest;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  r_oval;

    // payload
    t_delay  r_delay [LANE_COUNT];
    t_sample r_tap   [LANE_COUNT];

    t_delay   w_delay_in [LANE_COUNT];
    t_sample  w_lane_tap [LANE_COUNT];
    t_ring_wr w_wr;
    logic     w_accept;
    logic     w_move;

    assign w_delay_in[0] = i_delay_0;
    assign w_delay_in[1] = i_delay_1;
    assign w_delay_in[2] = i_delay_2;
    assign w_delay_in[3] = i_delay_3;
    assign w_delay_in[4] = i_delay_4;
    assign w_delay_in[5] = i_delay_5;
    assign w_delay_in[6] = i_delay_6;
    assign w_delay_in[7] = i_delay_7;

    // busy while clearing or while a transaction is in the lanes
    assign o_stall  = r_clr | (|r_vld);
    assign w_accept = i_valid & ~o_stall;
    // last lane stage hands its taps to the output register when that is free
    assign w_move   = r_vld[PIPE_DEPTH-1] & (~r_oval | ~i_stall);

    // ring write: clearing sweep zeroes one row of all banks, else push the sample
    always_comb begin
        w_wr = '0;
        if (r_clr) begin
            w_wr.we   = 1'b1;
            w_wr.clr  = 1'b1;
            w_wr.addr = ADDR_MAX_W'({r_row, 2'b00});
        end else begin
            w_wr.we   = w_accept & i_write_sample;
            w_wr.addr = ADDR_MAX_W'(r_newest + AW'(1));
            w_wr.data = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= 1'b1;
            r_row    <= '0;
            r_newest <= '0;
            r_vld    <= '0;
            r_oval   <= 1'b0;
        end else begin
            if (r_clr) begin
                r_row <= r_row + RW'(1);
                if (r_row == RW'(ROWS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (w_accept && i_write_sample) begin
                r_newest <= r_newest + AW'(1);
            end
            r_vld[0] <= w_accept;
            for (int s = 1; s < PIPE_DEPTH - 1; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_vld[PIPE_DEPTH-1] <= r_vld[PIPE_DEPTH-2] | (r_vld[PIPE_DEPTH-1] & ~w_move);
            if (w_move) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    // delays captured on acceptance and held for the lanes; taps taken on a move
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_delay <= w_delay_in;
        end
        if (w_move) begin
            r_tap <= w_lane_tap;
        end
    end

    // read lanes, each with its own ring copy
    for (genvar gl = 0; gl < LANE_COUNT; gl++) begin : g_lane
        chfdr_lane #(
            .RING_DEPTH (RING_DEPTH),
            .FRAC_BITS  (DELAY_FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_wr     (w_wr),
            .i_newest (r_newest),
            .i_delay  (r_delay[gl]),
            .o_tap    (w_lane_tap[gl])
        );
    end

    assign o_valid = r_oval;
    assign o_tap_0 = r_tap[0];
    assign o_tap_1 = r_tap[1];
    assign o_tap_2 = r_tap[2];
    assign o_tap_3 = r_tap[3];
    assign o_tap_4 = r_tap[4];
    assign o_tap_5 = r_tap[5];
    assign o_tap_6 = r_tap[6];
    assign o_tap_7 = r_tap[7];

endmodule

>>> rtl/chfdr_checker.sv
// port-level checks on the delay read block, bound to the top level
// depends on chfdr_pkg and cubic_hermite_fractional_delay_read_defines.svh
`include "cubic_hermite_fractional_delay_read_defines.svh"

module chfdr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input chfdr_pkg::t_sample o_tap_0,
    input chfdr_pkg::t_sample o_tap_7
);
    import chfdr_pkg::*;

    `CHFDR_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid, "stalled result dropped")
    `CHFDR_ASSERT_NEXT(a_tap_stable, o_valid && i_stall, $stable(o_tap_0) && $stable(o_tap_7), "stalled taps changed")
    `CHFDR_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "second transaction taken while busy")
    `CHFDR_ASSERT_NOW(a_clear_after_reset, $rose(i_rst_n), o_stall, "ring clear not running after reset")

endmodule

bind cubic_hermite_fractional_delay_read chfdr_checker u_chfdr_checker (.*);

>>> tb/chfdr_checker.sv
`timescale 1ns / 1ps
// checker for the cubic hermite fractional delay read block: a model of the delay
// ring predicts each result, accepted results are compared; depends on chfdr_pkg
module chfdr_tb_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               i_stall_in,
    input  logic                               i_write_sample,
    input  chfdr_pkg::t_sample                 i_sample,
    input  chfdr_pkg::t_delay [7:0]            i_delays,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  chfdr_pkg::t_sample [7:0]           i_taps,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import chfdr_pkg::*;

    localparam int RING = RING_DEPTH_DEF;
    localparam int FB   = FRAC_BITS_DEF;

    typedef t_sample [7:0] t_taps;

    t_sample     ring_model [RING];
    logic [11:0] newest;
    t_taps       expected_taps [$];

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd(longint v);
        return floor_sh(v + (longint'(1) << (FB - 1)), FB);
    endfunction

    function automatic longint rd(int idx);
        return longint'(ring_model[idx % RING]);
    endfunction

    function automatic t_sample interp_tap(t_delay dly);
        longint ym1, y0, y1, y2, d0, d1, dd, m0, m1, a, b, c, o, tt;
        int dint, idx;
        dint = int'(dly >> FB) % RING;
        idx  = (int'(newest) + RING - dint) % RING;
        if (dly[FB-1:0] != 0) begin
            idx = (idx + RING - 1) % RING;
            tt  = (longint'(1) << FB) - longint'(dly[FB-1:0]);
        end else begin
            tt = 0;
        end
        ym1 = rd(idx + RING - 1);
        y0  = rd(idx);
        y1  = rd(idx + 1);
        y2  = rd(idx + 2);
        d0 = y1 - ym1;
        d1 = y2 - y0;
        dd = y1 - y0;
        m0 = 6 * dd - 2 * d0 - d1;
        m1 = d0 - 4 * dd + d1;
        a = m0 + rnd(tt * m1);
        b = d0 + rnd(tt * a);
        c = 2 * y0 + rnd(tt * b);
        o = floor_sh(c + 1, 1);
        if (o > 32767) o = 32767;
        if (o < -32768) o = -32768;
        return t_sample'(o);
    endfunction

    assign o_pending = expected_taps.size();

    always @(posedge i_clk) begin
        t_taps exp_t;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (ring_model[k]) ring_model[k] = '0;
            newest = '0;
            expected_taps.delete();
            o_fail_count <= 0;
        end else begin
            // result side first: it cannot depend on the input taken this edge
            if (i_out_valid && !i_out_stall) begin
                if (expected_taps.size() == 0) begin
                    $error("unexpected result transaction");
                    errs++;
                end else begin
                    exp_t = expected_taps.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (i_taps[k] !== exp_t[k]) begin
                            $error("tap_%0d expected %0d actual %0d", k, exp_t[k], i_taps[k]);
                            errs++;
                        end
                    end
                end
            end
            if (errs != 0) begin
                o_fail_count <= o_fail_count + errs;
            end
            if (i_valid && !i_stall_in) begin
                if (i_write_sample) begin
                    newest = newest + 1'b1;
                    ring_model[newest] = i_sample;
                end
                for (int k = 0; k < 8; k++) exp_t[k] = interp_tap(i_delays[k]);
                expected_taps.push_back(exp_t);
            end
        end
    end
endmodule

>>> tb/tb_cubic_hermite_fractional_delay_read.sv
`timescale 1ns / 1ps
// top of the cubic hermite fractional delay read testbench: stimulus and verdict
// depends on chfdr_pkg, the block and chfdr_tb_checker
module tb_cubic_hermite_fractional_delay_read;
    import chfdr_pkg::*;

    localparam int N_RANDOM  = 1200;
    localparam int WD_LIMIT  = 20000;   // clearing pass plus long receiver hold-offs
    localparam int HOLD_LEN  = 200;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, i_write_sample, o_valid, i_stall;
    t_sample i_sample;
    t_delay [7:0] delays;
    t_sample [7:0] taps;
    int fail_count, pending;
    int src_idle_pct, dst_idle_pct;
    logic hold_req;         // asks the receiver for one long hold-off
    int watchdog;

    cubic_hermite_fractional_delay_read uut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_write_sample, .i_sample,
        .i_delay_0(delays[0]), .i_delay_1(delays[1]), .i_delay_2(delays[2]),
        .i_delay_3(delays[3]), .i_delay_4(delays[4]), .i_delay_5(delays[5]),
        .i_delay_6(delays[6]), .i_delay_7(delays[7]),
        .o_valid, .i_stall,
        .o_tap_0(taps[0]), .o_tap_1(taps[1]), .o_tap_2(taps[2]), .o_tap_3(taps[3]),
        .o_tap_4(taps[4]), .o_tap_5(taps[5]), .o_tap_6(taps[6]), .o_tap_7(taps[7])
    );

    chfdr_tb_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_write_sample, .i_sample,
        .i_delays(delays), .i_out_valid(o_valid), .i_out_stall(i_stall), .i_taps(taps),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stall, or a long counted hold-off on request
    initial begin
        int hold_cnt;
        i_stall = 1'b1;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_cnt == 0) hold_cnt = HOLD_LEN;
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < dst_idle_pct);
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
            if (watchdog >= WD_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // random delay: mostly short with random fraction, some whole, some huge
    function automatic t_delay rand_delay();
        case ($urandom_range(9))
            0: return t_delay'($urandom);
            1: return t_delay'({$urandom_range(4095), 16'h0});
            2: return 28'hFFF_FFFF;
            3: return t_delay'({$urandom_range(7), 16'h0000}) | t_delay'($urandom_range(1));
            default: return t_delay'({$urandom_range(40), 16'h0}) | t_delay'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_sample rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return t_sample'($urandom);
        endcase
    endfunction

    // one input transaction; the sender gap comes first so valid stays high across items
    task automatic send_item(logic wr, t_sample s, t_delay [7:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_write_sample <= wr;
        i_sample       <= s;
        delays         <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        t_delay [7:0] d;
        for (int i = 0; i < n; i++) begin
            foreach (d[k]) d[k] = rand_delay();
            send_item($urandom_range(3) != 0, rand_sample(), d);
        end
    endtask

    initial begin
        t_delay [7:0] d;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_write_sample = 1'b0;
        i_sample = '0;
        delays = '0;
        hold_req = 1'b0;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: cleared ring reads, full-scale pushes, whole and fractional delays,
        // delays that wrap past the ring and hit the oldest data
        foreach (d[k]) d[k] = '0;
        send_item(1'b0, '0, d);
        send_item(1'b1, 16'sh7FFF, d);
        send_item(1'b1, 16'sh8000, d);
        send_item(1'b1, 16'sh7FFF, d);
        send_item(1'b1, 16'sh8000, d);
        d = '{28'hFFF_FFFF, 28'h000_8000, 28'h001_0000, 28'h000_0001,
              28'h002_FFFF, 28'h100_0000, 28'hFFF_0000, 28'h555_AAAA};
        send_item(1'b0, '0, d);
        send_item(1'b1, 16'sh5555, d);
        send_item(1'b1, 16'shAAAA, d);
        send_item(1'b1, '0, d);
        d = '{28'h000_C000, 28'h001_4000, 28'h003_0001, 28'h0FF_F000,
              28'hAAA_5555, 28'h001_FFFF, 28'h000_FFFF, 28'h004_0000};
        send_item(1'b1, 16'sh7FFF, d);
        send_item(1'b1, 16'sh8001, d);
        send_item(1'b0, 16'shFFFF, d);

        // long receiver hold-off while items keep coming
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        send_random(30);

        src_idle_pct = 32; dst_idle_pct = 75;
        send_random(N_RANDOM / 3);
        // sender pauses until every result is back
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        src_idle_pct = 75; dst_idle_pct = 32;
        send_random(N_RANDOM / 3);
        src_idle_pct = 0; dst_idle_pct = 0;
        send_random(N_RANDOM / 3);
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
